[src/dlr_pkg.sv]
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and constants of the DDA line rasterizer: the field widths of
// the stream ports and the one-hot sequencer state encoding.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Width of every coordinate field on the stream ports.
    localparam int FIELD_W     = 6;
    // Input tdata carries four coordinates.
    localparam int IN_TDATA_W  = 4 * FIELD_W;
    // Output tdata carries two coordinates, padded up to whole bytes.
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * FIELD_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

[src/dda_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// DDA line rasterizer: takes one segment and streams out its grid cells.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one segment per transfer (x_start, y_start, x_end,
// y_end). The master stream returns one cell per transfer, in ascending order
// of the major axis, with tlast on the final cell of the segment. Equal
// endpoints give a single cell.
// Timing: the accept cycle loads the walk registers; the output register then
// takes the first cell once it is free. A segment of n cells (n = |dmajor| + 1,
// up to 2^COORD_BITS = 64) keeps the block busy, one cell per cycle while
// i_m_tready is high, since the single error accumulator unit produces one
// step per cycle. o_s_tready is high only between segments.
// Stalls: when i_m_tready is low the output register holds its cell and the
// walk pauses; nothing is lost or repeated.
// Reset: synchronous, active low; the block comes up idle with no output.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [5:0] x_start, [11:6] y_start, [17:12] x_end, [23:18] y_end
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [5:0] cell_x, [11:6] cell_y, [15:12] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // last_cell
    output logic                   o_m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int RW = CB + 3;
    localparam int IW = CB + 2;
    localparam int DW = CB + 1;

    // Control registers
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Walk registers
    logic                 r_x_major, n_x_major;
    logic [CB-1:0]        r_major, n_major;
    logic [CB-1:0]        r_major_hi, n_major_hi;
    logic [CB-1:0]        r_minor, n_minor;
    logic signed [RW-1:0] r_rem, n_rem;
    logic signed [IW-1:0] r_inc, n_inc;
    logic [DW-1:0]        r_two_d, n_two_d;

    // Output register
    logic [FIELD_W-1:0] r_cell_x, n_cell_x;
    logic [FIELD_W-1:0] r_cell_y, n_cell_y;
    logic               r_last, n_last;

    // Setup decode of the incoming segment
    logic [CB-1:0]        x0, y0, xn, yn;
    logic signed [CB:0]   dx, dy, dmin;
    logic [CB-1:0]        adx, ady;
    logic                 x_major, swap;
    logic [CB-1:0]        lo_maj, lo_min, hi_maj, hi_min, dmaj;

    logic                 s_xfer, out_free, at_end;
    logic signed [RW-1:0] step_rem;
    logic [CB-1:0]        step_minor;

    assign x0 = i_s_tdata[0*FIELD_W +: CB];
    assign y0 = i_s_tdata[1*FIELD_W +: CB];
    assign xn = i_s_tdata[2*FIELD_W +: CB];
    assign yn = i_s_tdata[3*FIELD_W +: CB];

    always_comb begin
        dx      = $signed({1'b0, xn}) - $signed({1'b0, x0});
        dy      = $signed({1'b0, yn}) - $signed({1'b0, y0});
        adx     = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ady     = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        x_major = (adx >= ady);
        // Walk always starts from the endpoint with the smaller major value.
        swap    = x_major ? (xn < x0) : (yn < y0);
        if (x_major) begin
            lo_maj = swap ? xn : x0;
            lo_min = swap ? yn : y0;
            hi_maj = swap ? x0 : xn;
            hi_min = swap ? y0 : yn;
        end else begin
            lo_maj = swap ? yn : y0;
            lo_min = swap ? xn : x0;
            hi_maj = swap ? y0 : yn;
            hi_min = swap ? x0 : xn;
        end
        dmaj = hi_maj - lo_maj;
        dmin = $signed({1'b0, hi_min}) - $signed({1'b0, lo_min});
    end

    dlr_err_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_err_unit (
        .i_rem   (r_rem),
        .i_inc   (r_inc),
        .i_two_d (r_two_d),
        .i_minor (r_minor),
        .o_rem   (step_rem),
        .o_minor (step_minor)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign at_end     = (r_major == r_major_hi);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_tready;
        n_x_major   = r_x_major;
        n_major     = r_major;
        n_major_hi  = r_major_hi;
        n_minor     = r_minor;
        n_rem       = r_rem;
        n_inc       = r_inc;
        n_two_d     = r_two_d;
        n_cell_x    = r_cell_x;
        n_cell_y    = r_cell_y;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    // Rounded half up start: value m_lo, remainder D of 2*D.
                    n_x_major  = x_major;
                    n_major    = lo_maj;
                    n_major_hi = hi_maj;
                    n_minor    = lo_min;
                    n_rem      = $signed({3'b000, dmaj});
                    n_inc      = {dmin, 1'b0};
                    n_two_d    = {dmaj, 1'b0};
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_cell_x    = r_x_major ? FIELD_W'(r_major) : FIELD_W'(r_minor);
                    n_cell_y    = r_x_major ? FIELD_W'(r_minor) : FIELD_W'(r_major);
                    n_last      = at_end;
                    n_major     = r_major + CB'(1);
                    n_minor     = step_minor;
                    n_rem       = step_rem;
                    if (at_end) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_major  <= n_x_major;
        r_major    <= n_major;
        r_major_hi <= n_major_hi;
        r_minor    <= n_minor;
        r_rem      <= n_rem;
        r_inc      <= n_inc;
        r_two_d    <= n_two_d;
        r_cell_x   <= n_cell_x;
        r_cell_y   <= n_cell_y;
        r_last     <= n_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {OUT_PAD_W'(0), r_cell_y, r_cell_x};
    assign o_m_tlast  = r_last;

`ifndef ASSERT_OFF
    a_accept_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> (r_state == ST_RUN))
        else $error("accepted segment did not start a walk");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |->
            (r_rem >= 0) && ((r_two_d == '0) || (r_rem < $signed({2'b00, r_two_d}))))
        else $error("error remainder left its range");

    a_major_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_major <= r_major_hi))
        else $error("major coordinate passed the segment end");
`endif

endmodule

[src/dlr_err_unit.sv]
// ----------------------------------------------------------------------------
// dlr_err_unit
// Error accumulator step of the DDA. Adds the doubled minor delta to the
// running remainder and folds it back into [0, 2*D) with one correction,
// moving the rounded minor coordinate up or down by one.
// ----------------------------------------------------------------------------
module dlr_err_unit #(
    parameter int COORD_BITS = 6
) (
    input  logic signed [COORD_BITS+2:0] i_rem,
    input  logic signed [COORD_BITS+1:0] i_inc,
    input  logic        [COORD_BITS:0]   i_two_d,
    input  logic        [COORD_BITS-1:0] i_minor,
    output logic signed [COORD_BITS+2:0] o_rem,
    output logic        [COORD_BITS-1:0] o_minor
);

    localparam int RW = COORD_BITS + 3;

    logic signed [RW-1:0] sum;
    logic signed [RW-1:0] two_d_s;

    assign two_d_s = $signed({2'b00, i_two_d});

    // The increment never exceeds 2*D in magnitude, so a single correction
    // brings the remainder back into range.
    always_comb begin
        sum = i_rem + RW'(i_inc);
        if (sum >= two_d_s) begin
            o_rem   = sum - two_d_s;
            o_minor = i_minor + COORD_BITS'(1);
        end else if (sum < 0) begin
            o_rem   = sum + two_d_s;
            o_minor = i_minor - COORD_BITS'(1);
        end else begin
            o_rem   = sum;
            o_minor = i_minor;
        end
    end

endmodule

[tb/tb_dda_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer_core
// Drives line segments into the rasterizer and checks every emitted cell
// against a behavioral DDA plot computed in the bench, with random idling on
// both streams, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer_core;
    import dlr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic               last;
    } t_cell;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [5:0] x_start, [11:6] y_start, [17:12] x_end, [23:18] y_end
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [5:0] cell_x, [11:6] cell_y, [15:12] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    t_cell cells_pending[$];
    int    errors = 0;
    int    tx_idle_pct = 33;
    int    rx_idle_pct = 33;
    int    hold_requests = 0;
    int    hold_taken = 0;
    int    hold_left = 0;

    dda_line_rasterizer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // Minor coordinate at major step t, rounded half up, in exact integers.
    function automatic int minor_at(int m0, int dm, int dmaj, int t);
        int num;
        int den;
        num = 2 * m0 * dmaj + 2 * dm * t + dmaj;
        den = 2 * dmaj;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num < 0) begin
            return 0;
        end
        return num / den;
    endfunction

    // Appends the cells of one segment to the queue of pending cells.
    function automatic void plot_segment(logic [FIELD_W-1:0] xs, logic [FIELD_W-1:0] ys,
                                         logic [FIELD_W-1:0] xe, logic [FIELD_W-1:0] ye);
        int    dx;
        int    dy;
        int    lo;
        int    hi;
        t_cell c;
        dx = int'(xe) - int'(xs);
        dy = int'(ye) - int'(ys);
        if (dx == 0 && dy == 0) begin
            c.x = xs;
            c.y = ys;
            c.last = 1'b1;
            cells_pending.push_back(c);
            return;
        end
        if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) begin
            lo = (xs < xe) ? int'(xs) : int'(xe);
            hi = (xs < xe) ? int'(xe) : int'(xs);
            for (int m = lo; m <= hi; m++) begin
                c.x = FIELD_W'(m);
                c.y = FIELD_W'(minor_at(int'(ys), dy, dx, m - int'(xs)));
                c.last = (m == hi);
                cells_pending.push_back(c);
            end
        end else begin
            lo = (ys < ye) ? int'(ys) : int'(ye);
            hi = (ys < ye) ? int'(ye) : int'(ys);
            for (int m = lo; m <= hi; m++) begin
                c.x = FIELD_W'(minor_at(int'(xs), dx, dy, m - int'(ys)));
                c.y = FIELD_W'(m);
                c.last = (m == hi);
                cells_pending.push_back(c);
            end
        end
    endfunction

    // Output side: random idling, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compares each cell transfer with the oldest pending cell.
    always @(posedge i_clk) begin
        t_cell want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (cells_pending.size() == 0) begin
                $error("unexpected cell x=%0d y=%0d last=%0b",
                       o_m_tdata[FIELD_W-1:0], o_m_tdata[2*FIELD_W-1:FIELD_W], o_m_tlast);
                errors++;
            end else begin
                want = cells_pending.pop_front();
                if (o_m_tdata[FIELD_W-1:0] !== want.x) begin
                    $error("cell_x: expected %0d, got %0d", want.x, o_m_tdata[FIELD_W-1:0]);
                    errors++;
                end
                if (o_m_tdata[2*FIELD_W-1:FIELD_W] !== want.y) begin
                    $error("cell_y: expected %0d, got %0d", want.y,
                           o_m_tdata[2*FIELD_W-1:FIELD_W]);
                    errors++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_cell: expected %0b, got %0b", want.last, o_m_tlast);
                    errors++;
                end
                if (o_m_tdata[OUT_TDATA_W-1:2*FIELD_W] !== '0) begin
                    $error("pad: expected 0, got %0h", o_m_tdata[OUT_TDATA_W-1:2*FIELD_W]);
                    errors++;
                end
            end
        end
    end

    // Offers one segment and returns once its transfer has happened.
    task automatic send_segment(logic [FIELD_W-1:0] xs, logic [FIELD_W-1:0] ys,
                                logic [FIELD_W-1:0] xe, logic [FIELD_W-1:0] ye);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {ye, xe, ys, xs};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        plot_segment(xs, ys, xe, ye);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (cells_pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_segment(5, 5, 5, 5);        // degenerate segment
        send_segment(0, 0, 0, 0);
        send_segment(63, 63, 63, 63);
        send_segment(0, 0, 63, 0);       // full-width horizontal
        send_segment(63, 0, 0, 0);       // same, endpoints reversed
        send_segment(0, 0, 0, 63);       // full-height vertical
        send_segment(0, 63, 0, 0);
        send_segment(0, 0, 63, 63);      // diagonal ties go to the x axis
        send_segment(63, 0, 0, 63);
        send_segment(10, 20, 20, 10);
        send_segment(0, 0, 63, 31);
        send_segment(0, 0, 63, 32);
        send_segment(0, 0, 2, 1);        // minor value lands exactly on one half
        send_segment(2, 1, 0, 0);
        send_segment(1, 0, 0, 2);
        send_segment(7, 3, 1, 0);
        send_segment(0, 0, 31, 63);      // steep
        send_segment(63, 63, 32, 0);
        send_segment(20, 40, 22, 41);
        send_segment(42, 21, 21, 42);
        wait_drained();
    endtask

    // Holds the output off while segments keep coming, so the block stalls its input.
    task automatic test_output_holdoff();
        tx_idle_pct   <= 0;
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < 6; k++) begin
            send_segment(FIELD_W'($urandom_range(0, 15)), FIELD_W'($urandom),
                         FIELD_W'($urandom_range(40, 63)), FIELD_W'($urandom));
        end
        tx_idle_pct <= 33;
        wait_drained();
    endtask

    task automatic send_random_segment();
        logic [FIELD_W-1:0] xs, ys, xe, ye;
        int kind;
        xs = FIELD_W'($urandom);
        ys = FIELD_W'($urandom);
        xe = FIELD_W'($urandom);
        ye = FIELD_W'($urandom);
        kind = $urandom_range(99);
        if (kind < 25) begin
            // Short segment near the start point.
            xe = FIELD_W'(int'(xs) + $urandom_range(0, 6) - 3);
            ye = FIELD_W'(int'(ys) + $urandom_range(0, 6) - 3);
        end else if (kind < 30) begin
            xe = xs;
            ye = ys;
        end else if (kind < 38) begin
            if (kind[0]) xe = xs; else ye = ys;
        end else if (kind < 45) begin
            ye = FIELD_W'(int'(ys) + ((int'(xe) - int'(xs)) * (kind[0] ? 1 : -1)));
        end
        send_segment(xs, ys, xe, ye);
    endtask

    task automatic test_random();
        for (int k = 0; k < 84; k++) begin
            send_random_segment();
        end
        // A stretch with no idling on either side.
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        for (int k = 0; k < 40; k++) begin
            send_random_segment();
        end
        tx_idle_pct <= 33;
        rx_idle_pct <= 33;
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_output_holdoff();
        test_random();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[dda_line_rasterizer_core.f]
src/dlr_pkg.sv
src/dlr_err_unit.sv
src/dda_line_rasterizer_core.sv
tb/tb_dda_line_rasterizer_core.sv
